// ===== rtl/core/aesd_pkg.sv =====
// ----------------------------------------------------------------------------
// aesd_pkg: shared types, constants and byte functions for the AES decryptor
// Holds the key size, the round count, the key config index codes and the GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesd_pkg;
    localparam int KEY_WORDS = 4;
    localparam int NR        = KEY_WORDS + 6;
    localparam int NWORDS    = 4 * (NR + 1);
    localparam int RK_AW     = $clog2(NR + 1);
    localparam int W_AW      = $clog2(NWORDS + 1);
    localparam int KW_AW     = $clog2(KEY_WORDS + 1);

    localparam logic [1:0] CFG_KEY_0 = 2'd0;
    localparam logic [1:0] CFG_KEY_1 = 2'd1;
    localparam logic [1:0] CFG_KEY_2 = 2'd2;
    localparam logic [1:0] CFG_KEY_3 = 2'd3;

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_block;

    function automatic t_byte gf_dbl(input t_byte x);
        gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte p;
        t_byte aa;
        p  = 8'h00;
        aa = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p = p ^ aa;
            aa = gf_dbl(aa);
        end
        gf_mul = p;
    endfunction

    function automatic t_byte gf_inv(input t_byte x);
        t_byte r;
        t_byte base;
        logic [7:0] e;
        r    = 8'h01;
        base = x;
        e    = 8'd254;
        for (int k = 0; k < 8; k++) begin
            if (e[k]) r = gf_mul(r, base);
            base = gf_mul(base, base);
        end
        gf_inv = r;
    endfunction

    function automatic t_byte rotl8(input t_byte x, input int n);
        rotl8 = t_byte'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic t_byte sbox_calc(input t_byte x);
        t_byte b;
        b = gf_inv(x);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic t_byte isbox_calc(input t_byte y);
        isbox_calc = gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
    endfunction

    typedef t_byte t_sbox [256];

    function automatic t_sbox build_sbox(input logic inv);
        t_sbox s;
        for (int i = 0; i < 256; i++) begin
            s[i] = inv ? isbox_calc(t_byte'(i)) : sbox_calc(t_byte'(i));
        end
        build_sbox = s;
    endfunction

    localparam t_sbox SBOX  = build_sbox(1'b0);
    localparam t_sbox ISBOX = build_sbox(1'b1);

    // Byte n sits at bits 127-8n.
    function automatic t_byte byte_at(input t_block s, input int n);
        byte_at = s[127 - 8 * n -: 8];
    endfunction

    function automatic t_block inv_shift_sub(input t_block s);
        t_block o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8 * (4 * c + r) -: 8] = ISBOX[byte_at(s, 4 * ((c + 4 - r) % 4) + r)];
            end
        end
        inv_shift_sub = o;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block o;
        t_byte a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(s, 4 * c);
            a1 = byte_at(s, 4 * c + 1);
            a2 = byte_at(s, 4 * c + 2);
            a3 = byte_at(s, 4 * c + 3);
            o[127 - 32 * c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                                 ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
            o[119 - 32 * c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                                 ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
            o[111 - 32 * c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                                 ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
            o[103 - 32 * c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                                 ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
        end
        inv_mix = o;
    endfunction
endpackage

// ===== rtl/core/aes_block_decrypt.sv =====
// ----------------------------------------------------------------------------
// aes_block_decrypt: AES inverse cipher, one 128-bit block per request
// ----------------------------------------------------------------------------
// One shared round unit is reused for every round. A block is taken when the
// block is idle, no key write is present and the key schedule is done. It then
// runs the initial key addition plus NR rounds, one step per cycle against the
// round key memory. The result holds until it is delivered, and the block then
// returns to idle; no new block is taken before the last one is delivered.
// After reset and after each key write the schedule rebuilds the round keys one
// word a cycle, and no block is taken meanwhile.
module aes_block_decrypt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // cipher_hi[63:0], cipher_lo[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // plain_hi[63:0], plain_lo[127:64]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import aesd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [63:0]      r_key [4];
    logic [RK_AW-1:0] r_rnd, n_rnd;
    logic             r_first, n_first;
    t_block           r_s, n_s;
    logic [RK_AW-1:0] w_addr;
    t_block           w_rk, w_ss, w_ak;
    logic             w_busy, w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg = i_cfg_valid;

    aesd_key_expand u_kexp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cfg),
        .i_key     ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rk),
        .o_busy    (w_busy)
    );

    assign s_axis_tready = (r_state == ST_IDLE) && !w_busy && !w_cfg;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {r_s[63:0], r_s[127:64]};

    // request the key for the next round ahead, as the memory read is registered
    assign w_addr = (r_state == ST_IDLE) ? RK_AW'(NR) : r_rnd;

    always_comb begin
        w_ss = inv_shift_sub(r_s);
        w_ak = w_ss ^ w_rk;
        n_state = r_state;
        n_rnd   = r_rnd;
        n_first = r_first;
        n_s     = r_s;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_s     = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                    n_state = ST_RUN;
                    n_first = 1'b1;
                    n_rnd   = RK_AW'(NR - 1);
                end
            end
            ST_RUN: begin
                if (r_first) begin
                    n_s     = r_s ^ w_rk;
                    n_first = 1'b0;
                end else if (r_rnd == RK_AW'(NR - 1) + 1'b1) begin
                    n_s     = w_ak;
                    n_state = ST_OUT;
                end else begin
                    n_s = inv_mix(w_ak);
                end
                if (!r_first && r_rnd == '0) n_rnd = RK_AW'(NR);
                else if (r_rnd != RK_AW'(NR)) n_rnd = r_rnd - 1'b1;
                if (!r_first && r_rnd == RK_AW'(NR)) begin
                    n_s     = w_ak;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= 1'b0;
            r_rnd   <= '0;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_rnd   <= n_rnd;
            if (w_cfg) begin
                case (i_cfg_index)
                    CFG_KEY_0: r_key[0] <= i_cfg_data;
                    CFG_KEY_1: r_key[1] <= i_cfg_data;
                    CFG_KEY_2: r_key[2] <= i_cfg_data;
                    CFG_KEY_3: r_key[3] <= i_cfg_data;
                    default:   r_key[0] <= r_key[0];
                endcase
            end
        end
        r_s <= n_s;
    end
endmodule

// ===== rtl/core/aesd_key_expand.sv =====
// ----------------------------------------------------------------------------
// aesd_key_expand: sequential key schedule into the round key memory
// Builds one 32-bit word a cycle, writes each full round key, serves reads.
// ----------------------------------------------------------------------------
module aesd_key_expand (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [255:0]          i_key,
    input  logic [aesd_pkg::RK_AW-1:0] i_rd_addr,
    output aesd_pkg::t_block      o_rd_data,
    output logic                  o_busy
);
    import aesd_pkg::*;

    t_block mem [NR + 1];
    t_word  r_win [KEY_WORDS];          // last KEY_WORDS words
    t_word  n_win [KEY_WORDS];
    t_block r_acc, n_acc;
    logic [W_AW-1:0]  r_idx, n_idx;
    logic [KW_AW-1:0] r_mod, n_mod;
    t_byte  r_rc, n_rc;
    logic   r_busy, n_busy;
    t_block r_rd;

    t_word  w_t, w_new;
    logic   w_wr;

    always_comb begin
        w_t = r_win[KEY_WORDS - 1];
        if (r_mod == '0) begin
            w_t = {SBOX[w_t[23:16]] ^ r_rc, SBOX[w_t[15:8]], SBOX[w_t[7:0]], SBOX[w_t[31:24]]};
        end else if (KEY_WORDS > 6 && r_mod == KW_AW'(4)) begin
            w_t = {SBOX[w_t[31:24]], SBOX[w_t[23:16]], SBOX[w_t[15:8]], SBOX[w_t[7:0]]};
        end
        // first KEY_WORDS words come straight from the key
        if (r_idx < W_AW'(KEY_WORDS)) begin
            w_new = i_key[255 - 32 * r_idx -: 32];
        end else begin
            w_new = r_win[0] ^ w_t;
        end
        n_win = r_win;
        n_acc = r_acc;
        n_idx = r_idx;
        n_mod = r_mod;
        n_rc  = r_rc;
        n_busy = r_busy;
        w_wr  = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_mod  = '0;
            n_rc   = 8'h01;
        end else if (r_busy) begin
            for (int k = 0; k < KEY_WORDS - 1; k++) n_win[k] = r_win[k + 1];
            n_win[KEY_WORDS - 1] = w_new;
            n_acc = {r_acc[95:0], w_new};
            w_wr  = (r_idx[1:0] == 2'd3);
            if (r_idx >= W_AW'(KEY_WORDS) && r_mod == '0) n_rc = gf_dbl(r_rc);
            n_mod = (r_mod == KW_AW'(KEY_WORDS - 1)) ? '0 : r_mod + 1'b1;
            n_idx = r_idx + 1'b1;
            if (r_idx == W_AW'(NWORDS - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_mod  <= '0;
            r_rc   <= 8'h01;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_mod  <= n_mod;
            r_rc   <= n_rc;
        end
        r_win <= n_win;
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) mem[r_idx[W_AW-1:2]] <= n_acc;
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_busy;
endmodule
